/* rtl/mpl_pkg.sv */
`default_nettype none

package mpl_pkg;

   // Table size used when the top level is not overridden
   localparam int DEFAULT_MAX_TRIANGLES = 256;

   // Field and datapath widths
   localparam int COORD_W  = 16;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int DIST_W   = SQ_W + 1;
   localparam int COUNT_W  = 9;
   localparam int INDEX_W  = 8;
   localparam int HOW_W    = 2;
   localparam int SEARCH_CAP = 256;

   // Action codes on req_action
   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_LOCATE = 1'b1;

   // Codes on rsp_how_found
   typedef enum logic [HOW_W-1:0] {
      HOW_CONTAINS = 2'd0,
      HOW_NEAREST  = 2'd1,
      HOW_EMPTY    = 2'd2
   } how_found_type;

   // Sign of one edge test, as handed from an edge cell to the decision stage
   typedef struct packed {
      logic neg;
      logic pos;
   } side_flags_type;

endpackage

`default_nettype wire

/* rtl/mpl_ram.sv */
`default_nettype none

module mpl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/mpl_edge_cell.sv */
`default_nettype none

// One edge test: sign of (p - e) x (s - e), three register stages deep
module mpl_edge_cell (
   input  wire logic                         clock,
   input  wire logic [mpl_pkg::COORD_W-1:0]  px,
   input  wire logic [mpl_pkg::COORD_W-1:0]  py,
   input  wire logic [mpl_pkg::COORD_W-1:0]  sx,
   input  wire logic [mpl_pkg::COORD_W-1:0]  sy,
   input  wire logic [mpl_pkg::COORD_W-1:0]  ex,
   input  wire logic [mpl_pkg::COORD_W-1:0]  ey,
   output mpl_pkg::side_flags_type           flags
);

   logic signed [mpl_pkg::DIFF_W-1:0]   dpx_in, dsy_in, dsx_in, dpy_in;
   logic signed [mpl_pkg::DIFF_W-1:0]   dpx_ff, dsy_ff, dsx_ff, dpy_ff;
   logic signed [mpl_pkg::PROD_W-1:0]   m1_in, m2_in, m1_ff, m2_ff;
   logic signed [mpl_pkg::PROD_W:0]     side_in;
   mpl_pkg::side_flags_type             flags_in, flags_ff;

   // Take coordinate differences against the edge end point
   assign dpx_in = $signed({1'b0, px}) - $signed({1'b0, ex});
   assign dsy_in = $signed({1'b0, sy}) - $signed({1'b0, ey});
   assign dsx_in = $signed({1'b0, sx}) - $signed({1'b0, ex});
   assign dpy_in = $signed({1'b0, py}) - $signed({1'b0, ey});

   // Form both cross terms
   assign m1_in = dpx_ff * dsy_ff;
   assign m2_in = dsx_ff * dpy_ff;

   // Subtract and keep only the sign
   assign side_in = $signed({m1_ff[mpl_pkg::PROD_W-1], m1_ff})
                  - $signed({m2_ff[mpl_pkg::PROD_W-1], m2_ff});
   assign flags_in.neg = side_in[mpl_pkg::PROD_W];
   assign flags_in.pos = !side_in[mpl_pkg::PROD_W] && (side_in != '0);

   always_ff @(posedge clock) begin
      dpx_ff   <= dpx_in;
      dsy_ff   <= dsy_in;
      dsx_ff   <= dsx_in;
      dpy_ff   <= dpy_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      flags_ff <= flags_in;
   end

   assign flags = flags_ff;

endmodule

`default_nettype wire

/* rtl/mpl_dist_cell.sv */
`default_nettype none

// Squared distance from the query point to a center, three register stages deep
module mpl_dist_cell (
   input  wire logic                         clock,
   input  wire logic [mpl_pkg::COORD_W-1:0]  px,
   input  wire logic [mpl_pkg::COORD_W-1:0]  py,
   input  wire logic [mpl_pkg::COORD_W-1:0]  cx,
   input  wire logic [mpl_pkg::COORD_W-1:0]  cy,
   output logic      [mpl_pkg::DIST_W-1:0]   sq_dist
);

   logic signed [mpl_pkg::DIFF_W-1:0]  dx_in, dy_in, dx_ff, dy_ff;
   logic signed [mpl_pkg::PROD_W-1:0]  sqx_prod, sqy_prod;
   logic        [mpl_pkg::SQ_W-1:0]    sqx_ff, sqy_ff;
   logic        [mpl_pkg::DIST_W-1:0]  dist_in, dist_ff;

   // Take differences to the center
   assign dx_in = $signed({1'b0, px}) - $signed({1'b0, cx});
   assign dy_in = $signed({1'b0, py}) - $signed({1'b0, cy});

   // Square each; the result is nonnegative and fits the low bits
   assign sqx_prod = dx_ff * dx_ff;
   assign sqy_prod = dy_ff * dy_ff;

   // Add the two squares
   assign dist_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= sqx_prod[mpl_pkg::SQ_W-1:0];
      sqy_ff  <= sqy_prod[mpl_pkg::SQ_W-1:0];
      dist_ff <= dist_in;
   end

   assign sq_dist = dist_ff;

endmodule

`default_nettype wire

/* rtl/mesh_point_locate_top.sv */
`default_nettype none

// Channel    Ports                                     Handshake
// request    req_* fields                              start, busy (taken when start & !busy)
// response   rsp_triangle_index, rsp_how_found         rsp_strobe, one cycle, no backpressure
// register   csr_triangle_count                        csr_valid, csr_ready
//
// A load writes one entry and leaves busy low. A locate with L = min(count, table, 256)
// entries streams one table entry per cycle through the RAM read port and a three-stage
// chain of cells; the result strobes after the last entry leaves the chain, sooner on
// a containing hit, and in the cycle after the accept when L is zero.
// Synchronous active-high reset clears control state; the table holds its contents
// and entries are undefined until loaded. The response side cannot stall the block.

module mesh_point_locate_top #(
   parameter int MAX_TRIANGLES = mpl_pkg::DEFAULT_MAX_TRIANGLES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [mpl_pkg::INDEX_W-1:0]   req_entry_index,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_corner_a_x,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_corner_a_y,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_corner_b_x,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_corner_b_y,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_corner_c_x,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_corner_c_y,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_middle_x,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_middle_y,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_query_x,
   input  wire logic [mpl_pkg::COORD_W-1:0]   req_query_y,
   output logic                               rsp_strobe,
   output logic      [mpl_pkg::INDEX_W-1:0]   rsp_triangle_index,
   output logic      [mpl_pkg::HOW_W-1:0]     rsp_how_found,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mpl_pkg::COUNT_W-1:0]   csr_triangle_count
);

   localparam int AW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int IW  = (AW > mpl_pkg::INDEX_W) ? AW : mpl_pkg::INDEX_W;
   localparam int CAP = (MAX_TRIANGLES < mpl_pkg::SEARCH_CAP) ? MAX_TRIANGLES
                                                            : mpl_pkg::SEARCH_CAP;
   localparam logic [IW:0] MAX_W = (IW+1)'(MAX_TRIANGLES);
   localparam logic [mpl_pkg::COUNT_W-1:0] CAP_W = mpl_pkg::COUNT_W'(CAP);
   localparam int CW  = mpl_pkg::COORD_W;
   localparam int NST = 4;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   logic [mpl_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [mpl_pkg::COUNT_W-1:0]       limit_ff, limit_in, limit_req;
   logic [mpl_pkg::COUNT_W-1:0]       scan_k_ff, scan_k_in;
   logic [CW-1:0]                     qx_ff, qx_in, qy_ff, qy_in;
   logic [NST-1:0]                    stage_valid_ff, stage_valid_in;
   logic [mpl_pkg::INDEX_W-1:0]       stage_idx_ff [NST];
   logic [mpl_pkg::INDEX_W-1:0]       stage_idx_in [NST];
   logic [mpl_pkg::INDEX_W-1:0]       best_idx_ff, best_idx_in;
   logic [mpl_pkg::DIST_W-1:0]        best_dist_ff, best_dist_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [mpl_pkg::INDEX_W-1:0]       rsp_idx_ff, rsp_idx_in;
   mpl_pkg::how_found_type            rsp_how_ff, rsp_how_in;

   logic                              accept, load_go, query_go, issue;
   logic [IW-1:0]                     idx_ext;
   logic                              load_ok;
   logic [AW-1:0]                     wr_addr, rd_addr;
   logic [3*CW-1:0]                   x_rd, y_rd;
   logic [2*CW-1:0]                   c_rd;
   mpl_pkg::side_flags_type           edge_flags [3];
   logic [mpl_pkg::DIST_W-1:0]        center_dist;
   logic                              neg_any, pos_any, hit, closer, last, finish;
   logic [mpl_pkg::INDEX_W-1:0]       tail_idx;

   // Decode the request beat
   assign busy      = state_ff[1];
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign load_go   = accept && (req_action == mpl_pkg::ACTION_LOAD);
   assign query_go  = accept && (req_action == mpl_pkg::ACTION_LOCATE);

   // Drop loads beyond the table
   assign idx_ext = IW'(req_entry_index);
   assign load_ok = {1'b0, idx_ext} < MAX_W;
   assign wr_addr = idx_ext[AW-1:0];
   assign rd_addr = AW'(scan_k_ff);

   // Clamp the search length
   assign limit_req = (count_ff > CAP_W) ? CAP_W : count_ff;

   // Table memories
   mpl_ram #(.WIDTH(3*CW), .DEPTH(MAX_TRIANGLES), .AW(AW)) u_x_ram (
      .clock   (clock),
      .wr_en   (load_go && load_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_corner_c_x, req_corner_b_x, req_corner_a_x}),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   mpl_ram #(.WIDTH(3*CW), .DEPTH(MAX_TRIANGLES), .AW(AW)) u_y_ram (
      .clock   (clock),
      .wr_en   (load_go && load_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_corner_c_y, req_corner_b_y, req_corner_a_y}),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   mpl_ram #(.WIDTH(2*CW), .DEPTH(MAX_TRIANGLES), .AW(AW)) u_c_ram (
      .clock   (clock),
      .wr_en   (load_go && load_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_middle_x, req_middle_y}),
      .rd_addr (rd_addr),
      .rd_data (c_rd)
   );

   // Edge cells: a->b, b->c, c->a
   mpl_edge_cell u_edge_ab (
      .clock (clock), .px (qx_ff), .py (qy_ff),
      .sx (x_rd[CW-1:0]),      .sy (y_rd[CW-1:0]),
      .ex (x_rd[2*CW-1:CW]),   .ey (y_rd[2*CW-1:CW]),
      .flags (edge_flags[0])
   );

   mpl_edge_cell u_edge_bc (
      .clock (clock), .px (qx_ff), .py (qy_ff),
      .sx (x_rd[2*CW-1:CW]),   .sy (y_rd[2*CW-1:CW]),
      .ex (x_rd[3*CW-1:2*CW]), .ey (y_rd[3*CW-1:2*CW]),
      .flags (edge_flags[1])
   );

   mpl_edge_cell u_edge_ca (
      .clock (clock), .px (qx_ff), .py (qy_ff),
      .sx (x_rd[3*CW-1:2*CW]), .sy (y_rd[3*CW-1:2*CW]),
      .ex (x_rd[CW-1:0]),      .ey (y_rd[CW-1:0]),
      .flags (edge_flags[2])
   );

   mpl_dist_cell u_dist (
      .clock (clock), .px (qx_ff), .py (qy_ff),
      .cx (c_rd[2*CW-1:CW]), .cy (c_rd[CW-1:0]),
      .sq_dist (center_dist)
   );

   // Decide on the entry leaving the chain
   assign tail_idx = stage_idx_ff[NST-1];
   assign neg_any  = edge_flags[0].neg || edge_flags[1].neg || edge_flags[2].neg;
   assign pos_any  = edge_flags[0].pos || edge_flags[1].pos || edge_flags[2].pos;
   assign hit      = !(neg_any && pos_any);
   assign closer   = (tail_idx == '0) || (center_dist < best_dist_ff);
   assign last     = ({1'b0, tail_idx} == (limit_ff - 1'b1));
   assign finish   = stage_valid_ff[NST-1] && (hit || last);
   assign issue    = (state_ff == ST_SCAN) && (scan_k_ff < limit_ff);

   // Next state of the sequencer, the chain and the result beat
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      limit_in       = limit_ff;
      scan_k_in      = scan_k_ff;
      qx_in          = qx_ff;
      qy_in          = qy_ff;
      best_idx_in    = best_idx_ff;
      best_dist_in   = best_dist_ff;
      rsp_strobe_in  = 1'b0;
      rsp_idx_in     = rsp_idx_ff;
      rsp_how_in     = rsp_how_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_triangle_count;
      end

      // Advance the chain
      stage_valid_in[0] = issue;
      stage_idx_in[0]   = scan_k_ff[mpl_pkg::INDEX_W-1:0];
      for (int i = 1; i < NST; i++) begin
         stage_valid_in[i] = stage_valid_ff[i-1];
         stage_idx_in[i]   = stage_idx_ff[i-1];
      end
      if (issue) begin
         scan_k_in = scan_k_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               qx_in    = req_query_x;
               qy_in    = req_query_y;
               limit_in = limit_req;
               scan_k_in = '0;
               if (limit_req == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_idx_in    = '0;
                  rsp_how_in    = mpl_pkg::HOW_EMPTY;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (stage_valid_ff[NST-1] && !hit && closer) begin
               best_idx_in  = tail_idx;
               best_dist_in = center_dist;
            end
            if (finish) begin
               rsp_strobe_in  = 1'b1;
               rsp_idx_in     = (hit || closer) ? tail_idx : best_idx_ff;
               rsp_how_in     = hit ? mpl_pkg::HOW_CONTAINS : mpl_pkg::HOW_NEAREST;
               state_in       = ST_IDLE;
               stage_valid_in = '0;
            end
         end
         default: begin
            state_in       = ST_IDLE;
            stage_valid_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         limit_ff       <= '0;
         scan_k_ff      <= '0;
         stage_valid_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         limit_ff       <= limit_in;
         scan_k_ff      <= scan_k_in;
         stage_valid_ff <= stage_valid_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_how_ff   <= rsp_how_in;
      for (int i = 0; i < NST; i++) begin
         stage_idx_ff[i] <= stage_idx_in[i];
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_triangle_index = rsp_idx_ff;
   assign rsp_how_found      = rsp_how_ff;

`ifndef SYNTH
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_SCAN) ||
                     ($past(start) && !$past(busy) &&
                      ($past(req_action) == mpl_pkg::ACTION_LOCATE)))
      else $error("response beat without a locate in progress");

   a_chain_in_scan: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff[NST-1] |-> (state_ff == ST_SCAN))
      else $error("entry in the cell chain outside a scan");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      scan_k_ff <= limit_ff)
      else $error("scan index ran past the search length");

   a_hit_reported: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && stage_valid_ff[NST-1] && hit) |=>
         (rsp_strobe && (rsp_how_found == mpl_pkg::HOW_CONTAINS) && !busy))
      else $error("containing entry not reported on the next beat");
`endif

endmodule

`default_nettype wire
